// ===== design/ertab_pkg.sv =====
// Shared types and constants of the exchange retransmit table.
// Depends on nothing; imported by exchange_retransmit_table_unit.
`default_nettype none

package ertab_pkg;

	// Stream payload widths
	localparam int IN_DATA_W  = 80;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int ACTIVE_W   = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRANSMITS = 1'd1;

	localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
	localparam logic [3:0]  MAX_RETX_RESET = 4'd4;

	typedef enum logic [1:0] {
		ACT_INITIATE = 2'd0,
		ACT_RESPONSE = 2'd1,
		ACT_COMPLETE = 2'd2,
		ACT_TICK     = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		EV_ASSIGNED   = 3'd0,
		EV_FULL       = 3'd1,
		EV_RESPONSE   = 3'd2,
		EV_UNKNOWN    = 3'd3,
		EV_COMPLETED  = 3'd4,
		EV_RETRANSMIT = 3'd5,
		EV_TIMED_OUT  = 3'd6,
		EV_TICK_DONE  = 3'd7
	} evt_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CTRL,
		ST_WALK,
		ST_DRAIN_RD,
		ST_DRAIN_EMIT
	} fsm_t;

	// One table entry as held in the entry RAM
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] session;
		logic [7:0]  protocol;
		logic [7:0]  opcode;
		logic [31:0] stamp;
		logic [3:0]  retries;
	} entry_t;

	// One retransmit or timeout found by a tick walk
	typedef struct packed {
		logic        timed_out;
		logic [15:0] id;
		logic [15:0] session;
		logic [3:0]  retries;
	} tick_evt_t;

endpackage

`default_nettype wire

// ===== design/ertab_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module ertab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/exchange_retransmit_table_unit.sv =====
// Top level of the exchange retransmit table: control, flags, lookup and tick walk.
// Depends on ertab_pkg and ertab_ram.
`default_nettype none

// Channel   Direction  Signals                      Contents
// s_*       in         tvalid tready tdata tuser    one action per transaction
// m_*       out        tvalid tready tdata tuser    one or more results per action
//                      tlast                        tlast marks the final result
// cfg_*     in         we index data                register writes, no read-back
//
// Initiate and unknown-id results are loaded at the accept edge; response and complete
// first pass through the control state to read the session from the entry RAM. A tick
// walks the entry RAM one slot per cycle in the walk state, then, for each retransmit
// or timeout it found, reads it from the registered result RAM in the drain read state
// and loads it in the drain emit state, and loads the tick-done result after that.
// Reset clears the flags, counters and the FSM asynchronously; the RAMs are not
// cleared, since an entry is written in the same cycle as its valid flag is set.
// Input is taken only in the idle state and only when the output register can load;
// a stalled output holds the FSM in whichever state is waiting to load a result.

module exchange_retransmit_table_unit
	import ertab_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// exchange[15:0], session[31:16], protocol[39:32], opcode[47:40], now[79:48]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// action[1:0]
	input  wire logic [IN_USER_W-1:0]  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// result_id[15:0], result_session[31:16], retry_count[35:32], active_count[40:36],
	// zero fill[47:41]
	output logic      [OUT_DATA_W-1:0] m_tdata,
	// event_res[2:0]
	output logic      [OUT_USER_W-1:0] m_tuser,
	output logic                       m_tlast,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	// Configuration registers
	logic [31:0] timeout_q;
	logic [3:0]  max_retx_q;

	// Per-slot flags and the id lookup array
	logic [SLOTS-1:0] slot_valid_q;
	logic [SLOTS-1:0] slot_await_q;
	logic [SLOTS-1:0] slot_done_q;
	logic [15:0]      slot_id_q [SLOTS];
	logic [15:0]      next_id_q;
	logic [CW-1:0]    active_q;

	fsm_t state_q, state_d;

	// Input fields
	action_t     in_action;
	logic [15:0] in_xid;
	logic [15:0] in_ses;
	logic [7:0]  in_proto;
	logic [7:0]  in_op;
	logic [31:0] in_now;
	logic        accept;
	logic        out_free;

	// Lookup
	logic [15:0]      key;
	logic [SLOTS-1:0] hit_vec;
	logic             hit_any;
	logic [IW-1:0]    hit_idx;
	logic             free_any;
	logic [IW-1:0]    free_idx;
	logic             init_any;
	logic [IW-1:0]    init_idx;
	logic [CW-1:0]    init_inc;

	// Response and complete
	evt_t        ctrl_ev_q;
	logic [15:0] ctrl_id_q;

	// Tick walk
	logic [CW-1:0] ptr_q;
	logic          walk_v_s1;
	logic [IW-1:0] walk_idx_s1;
	logic [31:0]   now_q;
	logic [CW-1:0] evt_cnt_q;
	logic [CW-1:0] drain_q;
	entry_t        w_entry;
	logic          w_live;
	logic          w_done;
	logic          w_check;
	logic [31:0]   w_age;
	logic          w_expired;
	logic          w_retx;
	logic          w_tmo;

	// RAM ports
	logic          d_we;
	logic [IW-1:0] d_waddr;
	entry_t        d_wdata;
	logic          d_re;
	logic [IW-1:0] d_raddr;
	entry_t        d_rdata;
	logic          r_we;
	logic [IW-1:0] r_waddr;
	tick_evt_t     r_wdata;
	logic          r_re;
	logic [IW-1:0] r_raddr;
	tick_evt_t     r_rdata;

	// Output register
	logic                out_load;
	evt_t                out_ev;
	logic [15:0]         out_id;
	logic [15:0]         out_ses;
	logic [3:0]          out_retry;
	logic [ACTIVE_W-1:0] out_act;
	logic                out_last;
	logic                m_tvalid_q;
	evt_t                ev_q;
	logic [15:0]         res_id_q;
	logic [15:0]         res_ses_q;
	logic [3:0]          retry_q;
	logic [ACTIVE_W-1:0] act_q;
	logic                last_q;

	assign in_action = action_t'(s_tuser);
	assign in_xid    = s_tdata[15:0];
	assign in_ses    = s_tdata[31:16];
	assign in_proto  = s_tdata[39:32];
	assign in_op     = s_tdata[47:40];
	assign in_now    = s_tdata[79:48];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// An initiate looks for the id it is about to hand out, since a wrapped id
	// overwrites the slot that still holds it; response and complete look for theirs.
	assign key = (in_action == ACT_INITIATE) ? next_id_q : in_xid;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			hit_vec[i] = slot_valid_q[i] && (slot_id_q[i] == key);
		end
	end

	// Lowest-numbered match and lowest-numbered free slot
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = IW'(i);
			end
			if (!slot_valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign hit_any  = |hit_vec;
	assign free_any = ~&slot_valid_q;
	assign init_any = hit_any || free_any;
	assign init_idx = hit_any ? hit_idx : free_idx;
	// Overwriting a live entry leaves the count alone; reviving a done one adds one.
	assign init_inc = hit_any ? CW'(slot_done_q[hit_idx]) : CW'(1);

	// Tick walk, stage 1: the entry read in the previous cycle is examined here.
	assign w_entry   = d_rdata;
	assign w_live    = walk_v_s1 && slot_valid_q[walk_idx_s1];
	assign w_done    = w_live && slot_done_q[walk_idx_s1];
	assign w_check   = w_live && !slot_done_q[walk_idx_s1] && slot_await_q[walk_idx_s1];
	assign w_age     = now_q - w_entry.stamp;
	assign w_expired = w_check && (w_age > timeout_q);
	assign w_retx    = w_expired && (w_entry.retries < max_retx_q);
	assign w_tmo     = w_expired && !w_retx;

	always_comb begin
		state_d   = state_q;
		d_we      = 1'b0;
		d_waddr   = init_idx;
		d_wdata   = '{id: next_id_q, session: in_ses, protocol: in_proto, opcode: in_op,
			stamp: in_now, retries: 4'd0};
		d_re      = 1'b0;
		d_raddr   = hit_idx;
		r_we      = 1'b0;
		r_waddr   = evt_cnt_q[IW-1:0];
		r_wdata   = '{timed_out: w_tmo, id: w_entry.id, session: w_entry.session,
			retries: w_tmo ? 4'd0 : w_entry.retries + 4'd1};
		r_re      = 1'b0;
		r_raddr   = drain_q[IW-1:0];
		out_load  = 1'b0;
		out_ev    = EV_TICK_DONE;
		out_id    = '0;
		out_ses   = '0;
		out_retry = '0;
		out_act   = ACTIVE_W'(active_q);
		out_last  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_action)
						ACT_INITIATE: begin
							out_load = 1'b1;
							out_ses  = in_ses;
							if (init_any) begin
								d_we    = 1'b1;
								out_ev  = EV_ASSIGNED;
								out_id  = next_id_q;
								out_act = ACTIVE_W'(active_q + init_inc);
							end else begin
								out_ev = EV_FULL;
							end
						end
						ACT_RESPONSE, ACT_COMPLETE: begin
							if (hit_any) begin
								d_re    = 1'b1;
								state_d = ST_CTRL;
							end else begin
								out_load = 1'b1;
								out_ev   = EV_UNKNOWN;
								out_id   = in_xid;
							end
						end
						ACT_TICK: begin
							state_d = ST_WALK;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CTRL: begin
				if (out_free) begin
					out_load = 1'b1;
					out_ev   = ctrl_ev_q;
					out_id   = ctrl_id_q;
					out_ses  = d_rdata.session;
					state_d  = ST_IDLE;
				end
			end
			ST_WALK: begin
				if (ptr_q < CW'(SLOTS)) begin
					d_re    = 1'b1;
					d_raddr = ptr_q[IW-1:0];
				end else if (!walk_v_s1) begin
					state_d = ST_DRAIN_RD;
				end
				if (w_retx) begin
					d_we    = 1'b1;
					d_waddr = walk_idx_s1;
					d_wdata = '{id: w_entry.id, session: w_entry.session,
						protocol: w_entry.protocol, opcode: w_entry.opcode,
						stamp: now_q, retries: w_entry.retries + 4'd1};
				end
				r_we = w_expired;
			end
			ST_DRAIN_RD: begin
				if (drain_q < evt_cnt_q) begin
					r_re    = 1'b1;
					state_d = ST_DRAIN_EMIT;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_DRAIN_EMIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_ev    = r_rdata.timed_out ? EV_TIMED_OUT : EV_RETRANSMIT;
					out_id    = r_rdata.id;
					out_ses   = r_rdata.session;
					out_retry = r_rdata.retries;
					out_last  = 1'b0;
					state_d   = ST_DRAIN_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RESET;
			max_retx_q <= MAX_RETX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT_TICKS:   timeout_q  <= cfg_data;
				REG_MAX_RETRANSMITS: max_retx_q <= cfg_data[3:0];
				default: begin
					timeout_q <= timeout_q;
				end
			endcase
		end
	end

	// Flags, id counter and the count of live entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			slot_await_q <= '0;
			slot_done_q  <= '0;
			next_id_q    <= '0;
			active_q     <= '0;
		end else begin
			if (accept && (in_action == ACT_INITIATE) && init_any) begin
				slot_valid_q[init_idx] <= 1'b1;
				slot_await_q[init_idx] <= 1'b1;
				slot_done_q[init_idx]  <= 1'b0;
				next_id_q              <= next_id_q + 16'd1;
				active_q               <= active_q + init_inc;
			end
			if (accept && (in_action == ACT_RESPONSE) && hit_any) begin
				slot_await_q[hit_idx] <= 1'b0;
			end
			if (accept && (in_action == ACT_COMPLETE) && hit_any) begin
				slot_done_q[hit_idx] <= 1'b1;
				if (!slot_done_q[hit_idx]) begin
					active_q <= active_q - CW'(1);
				end
			end
			if (state_q == ST_WALK) begin
				if (w_done || w_tmo) begin
					slot_valid_q[walk_idx_s1] <= 1'b0;
				end
				if (w_tmo) begin
					active_q <= active_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (in_action == ACT_INITIATE) && init_any) begin
			slot_id_q[init_idx] <= next_id_q;
		end
		if (accept) begin
			ctrl_ev_q <= (in_action == ACT_RESPONSE) ? EV_RESPONSE : EV_COMPLETED;
			ctrl_id_q <= in_xid;
		end
	end

	// Walk and drain counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			walk_v_s1   <= 1'b0;
			walk_idx_s1 <= '0;
			now_q       <= '0;
			evt_cnt_q   <= '0;
			drain_q     <= '0;
		end else begin
			if (accept && (in_action == ACT_TICK)) begin
				ptr_q     <= '0;
				walk_v_s1 <= 1'b0;
				now_q     <= in_now;
				evt_cnt_q <= '0;
			end
			if (state_q == ST_WALK) begin
				walk_v_s1   <= d_re;
				walk_idx_s1 <= ptr_q[IW-1:0];
				if (d_re) begin
					ptr_q <= ptr_q + CW'(1);
				end
				if (w_expired) begin
					evt_cnt_q <= evt_cnt_q + CW'(1);
				end
				if (state_d == ST_DRAIN_RD) begin
					drain_q <= '0;
				end
			end
			if ((state_q == ST_DRAIN_EMIT) && out_free) begin
				drain_q <= drain_q + CW'(1);
			end
		end
	end

	ertab_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(SLOTS)
	) u_entry_ram (
		.clk  (clk),
		.we   (d_we),
		.waddr(d_waddr),
		.wdata(d_wdata),
		.re   (d_re),
		.raddr(d_raddr),
		.rdata(d_rdata)
	);

	ertab_ram #(
		.WIDTH($bits(tick_evt_t)),
		.DEPTH(SLOTS)
	) u_result_ram (
		.clk  (clk),
		.we   (r_we),
		.waddr(r_waddr),
		.wdata(r_wdata),
		.re   (r_re),
		.raddr(r_raddr),
		.rdata(r_rdata)
	);

	// Output register: it loads only when it is empty or its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ev_q      <= out_ev;
			res_id_q  <= out_id;
			res_ses_q <= out_ses;
			retry_q   <= out_retry;
			act_q     <= out_act;
			last_q    <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = ev_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {7'd0, act_q, retry_q, res_ses_q, res_id_q};

	// The live count always matches the flags it summarizes.
	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q & ~slot_done_q) == int'(active_q))
		else $error("active count out of step with slot flags");

	// The walk's second stage is only ever occupied during the walk.
	a_walk_stage: assert property (@(posedge clk) disable iff (!arst_n)
		walk_v_s1 |-> (state_q == ST_WALK))
		else $error("walk stage busy outside the walk");

	// A tick cannot find more events than there are slots.
	a_evt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(evt_cnt_q) <= SLOTS)
		else $error("tick event count exceeds slot count");

	// Tick done closes its action, while walk events never do.
	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == EV_TICK_DONE)) |-> m_tlast)
		else $error("tick done without tlast");

	a_walk_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ((m_tuser == EV_RETRANSMIT) || (m_tuser == EV_TIMED_OUT))) |-> !m_tlast)
		else $error("walk event marked last");

endmodule

`default_nettype wire
